// ----- rtl/pfg_pkg.sv -----
// shared constants, bound set table and arithmetic widths for the palette fade generator
`default_nettype none

package pfg_pkg;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam int NUM_BOUNDS = 6;
  localparam int NUM_SETS   = 8;

  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // reciprocals scaled by 2^16, exact for the operand ranges seen here
  localparam logic [15:0] RECIP_15 = 16'd4370;
  localparam logic [15:0] RECIP_13 = 16'd5042;

  localparam logic [7:0] MID_GREY    = 8'd128;
  localparam logic [3:0] SHADE_DIV   = 4'd13;
  localparam logic [7:0] LAST_ENTRY  = 8'd223;

  typedef logic [7:0] bound_t;

  localparam bound_t RESET_BOUNDS [NUM_BOUNDS] = '{8'd10, 8'd190, 8'd10, 8'd170, 8'd0, 8'd255};

  localparam bound_t BOUND_SETS [NUM_SETS][NUM_BOUNDS] = '{
    '{8'd10, 8'd190, 8'd10, 8'd170, 8'd0,  8'd255},
    '{8'd10, 8'd190, 8'd10, 8'd170, 8'd0,  8'd128},
    '{8'd40, 8'd200, 8'd10, 8'd170, 8'd0,  8'd255},
    '{8'd0,  8'd128, 8'd40, 8'd128, 8'd40, 8'd192},
    '{8'd40, 8'd140, 8'd40, 8'd140, 8'd0,  8'd140},
    '{8'd20, 8'd100, 8'd50, 8'd150, 8'd60, 8'd255},
    '{8'd0,  8'd200, 8'd0,  8'd150, 8'd0,  8'd255},
    '{8'd80, 8'd140, 8'd80, 8'd140, 8'd80, 8'd140}
  };

endpackage

`default_nettype wire

// ----- rtl/pfg_mul.sv -----
// shared unsigned multiplier with registered product
`default_nettype none

module pfg_mul (
  input  logic                        clk,
  input  logic [pfg_pkg::MUL_A_W-1:0] a,
  input  logic [pfg_pkg::MUL_B_W-1:0] b,
  output logic [pfg_pkg::MUL_P_W-1:0] prod
);
  import pfg_pkg::*;

  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

`default_nettype wire

// ----- rtl/palette_fade_generator.sv -----
// palette fade generator: fade sequencer, palette entry shading and config port
// read request: the shared multiplier works each of the three components in turn, then
//   the result is handed off; an out-of-range entry goes straight to hand-off as zero
// tick request: done at accept at a fade boundary or when fading is off, else each of
//   the six bounds is updated in turn; one request at a time
// synchronous reset loads the start bounds, clears the fade count and set index,
//   enables fading; captured bounds hold no reset value
`default_nettype none

module palette_fade_generator #(
  parameter int FADE_STEPS = 128
) (
  input  logic        clk,
  input  logic        rst,
  // apb config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] entry
  input  logic        s_tuser,   // [0] op
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);
  import pfg_pkg::*;

  localparam int RECIP_SHIFT = 24;
  localparam int FADE_RECIP  = (2**RECIP_SHIFT + FADE_STEPS - 1) / FADE_STEPS;

  typedef enum logic [1:0] {S_IDLE, S_TICK, S_READ, S_DONE} state_t;

  state_t           state;
  logic [2:0]       phase;
  logic [2:0]       k;
  logic             fade_enable;
  logic [7:0]       fade_count;
  logic [2:0]       set_index;
  bound_t           bounds [NUM_BOUNDS];
  bound_t           captured [NUM_BOUNDS];
  logic [7:0]       t_r;
  logic [15:0]      acc;
  logic [7:0]       lo_r;
  logic             neg_r;
  logic [3:0]       col_r;
  logic [3:0]       rowc_r;
  logic [2:0][7:0]  res;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;

  logic [2:0] bidx;
  bound_t     rd_bound;
  logic [8:0] diff;
  logic [7:0] diff_mag;
  logic [7:0] quot;
  logic [7:0] v;
  logic [7:0] w_mag;
  logic [7:0] shade;
  logic       in_accept;
  logic       cfg_write;

  assign in_accept = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == 1'b0) ? {31'd0, fade_enable} : 32'd0;

  pfg_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // lo is fetched in phase 0, hi from phase 1 on
  assign bidx     = (state == S_READ) ? {k[1:0], (phase != 3'd0)} : k;
  assign rd_bound = bounds[bidx];
  assign diff     = {1'b0, rd_bound} - {1'b0, lo_r};
  assign diff_mag = diff[8] ? 8'(-diff) : diff[7:0];
  assign quot     = prod[23:16];
  assign v        = neg_r ? (lo_r - quot) : (lo_r + quot);
  assign w_mag    = v[7] ? {1'b0, v[6:0]} : (MID_GREY - v);
  assign shade    = neg_r ? (MID_GREY - quot) : (MID_GREY + quot);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_TICK: begin
        case (phase)
          3'd0: begin
            mul_a = MUL_A_W'(t_r);
            mul_b = MUL_B_W'(captured[k]);
          end
          3'd1: begin
            mul_a = MUL_A_W'(8'(FADE_STEPS) - t_r);
            mul_b = MUL_B_W'(BOUND_SETS[set_index][k]);
          end
          3'd2: begin
            mul_a = MUL_A_W'(FADE_RECIP);
            mul_b = acc + prod[15:0];
          end
          default: ;
        endcase
      end
      S_READ: begin
        case (phase)
          3'd1: begin
            mul_a = MUL_A_W'(col_r);
            mul_b = MUL_B_W'(diff_mag);
          end
          3'd2: begin
            mul_a = MUL_A_W'(prod[11:0]);
            mul_b = RECIP_15;
          end
          3'd3: begin
            mul_a = MUL_A_W'(w_mag);
            mul_b = MUL_B_W'(rowc_r);
          end
          3'd4: begin
            mul_a = MUL_A_W'(prod[10:0]);
            mul_b = RECIP_13;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= '0;
      k           <= '0;
      fade_enable <= 1'b1;
      fade_count  <= '0;
      set_index   <= '0;
      m_tvalid    <= 1'b0;
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        bounds[i] <= RESET_BOUNDS[i];
      end
    end else begin
      if (cfg_write && paddr[2] == 1'b0) begin
        fade_enable <= pwdata[0];
      end
      // the hand-off state reloads the output itself when it is taken
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            phase <= '0;
            k     <= '0;
            if (s_tuser == OP_READ) begin
              if (s_tdata > LAST_ENTRY) begin
                res   <= '0;
                state <= S_DONE;
              end else begin
                col_r  <= s_tdata[3:0];
                rowc_r <= SHADE_DIV - s_tdata[7:4];
                state  <= S_READ;
              end
            end else if (fade_enable) begin
              if (fade_count != 8'd0) begin
                fade_count <= fade_count - 8'd1;
                t_r        <= fade_count - 8'd1;
                state      <= S_TICK;
              end else begin
                // fade finished: next target, present bounds become the origin
                set_index  <= set_index + 3'd1;
                fade_count <= 8'(FADE_STEPS);
                for (int i = 0; i < NUM_BOUNDS; i++) begin
                  captured[i] <= bounds[i];
                end
              end
            end
          end
        end
        S_TICK: begin
          case (phase)
            3'd1: begin
              acc   <= prod[15:0];
              phase <= phase + 3'd1;
            end
            3'd3: begin
              bounds[k] <= prod[31:24];
              phase     <= '0;
              if (k == 3'(NUM_BOUNDS - 1)) begin
                state <= S_IDLE;
              end else begin
                k <= k + 3'd1;
              end
            end
            default: phase <= phase + 3'd1;
          endcase
        end
        S_READ: begin
          case (phase)
            3'd0: begin
              lo_r  <= rd_bound;
              phase <= phase + 3'd1;
            end
            3'd1: begin
              neg_r <= diff[8];
              phase <= phase + 3'd1;
            end
            3'd3: begin
              neg_r <= !v[7];
              phase <= phase + 3'd1;
            end
            3'd5: begin
              res[k[1:0]] <= shade;
              phase       <= '0;
              if (k == 3'd2) begin
                state <= S_DONE;
              end else begin
                k <= k + 3'd1;
              end
            end
            default: phase <= phase + 3'd1;
          endcase
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= res;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    fade_count <= 8'(FADE_STEPS))
    else $error("fade count above fade length");

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_tuser == OP_TICK && fade_enable && fade_count == 8'd0)
      |=> (fade_count == 8'(FADE_STEPS) && state == S_IDLE))
    else $error("fade not rearmed at boundary");

  a_no_tick_when_off: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_tuser == OP_TICK && !fade_enable) |=> $stable(fade_count) && state == S_IDLE)
    else $error("tick changed state while fading disabled");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result presented outside hand-off");

  a_out_of_range: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_tuser == OP_READ && s_tdata > LAST_ENTRY) |=> (state == S_DONE && res == '0))
    else $error("out-of-range entry not zeroed");

endmodule

`default_nettype wire
